[src/malu_pkg.sv]
// Shared definitions for the MIPS integer ALU with HI/LO multiply and divide.
// Holds operation codes, sequencer states, port widths and unit control structs.
// No dependencies.
`default_nettype none

package malu_pkg;

    localparam int WORD_W   = 32;
    localparam int OP_W     = 5;
    localparam int IMM_W    = 16;
    localparam int SHAMT_W  = 5;
    localparam int S_TDATA_W = 88;
    localparam int M_TDATA_W = 32;
    localparam int STEP_CNT_W = 5;

    // Operation codes as carried on the request side.
    typedef enum logic [OP_W-1:0] {
        OP_ADD   = 5'd0,
        OP_SUB   = 5'd1,
        OP_ADDI  = 5'd2,
        OP_ADDU  = 5'd3,
        OP_SUBU  = 5'd4,
        OP_ADDIU = 5'd5,
        OP_DIV   = 5'd6,
        OP_MULT  = 5'd7,
        OP_SLL   = 5'd8,
        OP_SRL   = 5'd9,
        OP_SRA   = 5'd10,
        OP_SLLV  = 5'd11,
        OP_SRLV  = 5'd12,
        OP_SRAV  = 5'd13,
        OP_MFHI  = 5'd14,
        OP_MTHI  = 5'd15,
        OP_MFLO  = 5'd16,
        OP_MTLO  = 5'd17
    } op_t;

    // Sequencer states of the top level.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_ITER,
        ST_DONE
    } state_t;

    // Command from the sequencer to the multiply/divide unit.
    typedef struct packed {
        logic start;
        logic is_div;
    } md_cmd_t;

    // Status from the multiply/divide unit back to the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } md_stat_t;

endpackage

`default_nettype wire

[src/malu_alu.sv]
// Combinational datapath for add, subtract, shifts and moves from HI/LO.
// Depends on malu_pkg for operation codes and widths.
`default_nettype none

module malu_alu
    import malu_pkg::*;
(
    input  op_t               op,
    input  logic [WORD_W-1:0] src_a,
    input  logic [WORD_W-1:0] src_b,
    input  logic [IMM_W-1:0]  immediate,
    input  logic [SHAMT_W-1:0] shift_amount,
    input  logic [WORD_W-1:0] hi_val,
    input  logic [WORD_W-1:0] lo_val,
    output logic [WORD_W-1:0] result,
    output logic              writes_register
);

    logic [WORD_W-1:0]  simm;
    logic [SHAMT_W-1:0] var_amt;

    // Sign-extended immediate and the register shift amount.
    assign simm    = {{(WORD_W-IMM_W){immediate[IMM_W-1]}}, immediate};
    assign var_amt = src_a[SHAMT_W-1:0];

    // Operation select; operations without a register result give zero.
    always_comb begin
        result          = '0;
        writes_register = 1'b1;
        case (op)
            OP_ADD, OP_ADDU:   result = src_a + src_b;
            OP_SUB, OP_SUBU:   result = src_a - src_b;
            OP_ADDI, OP_ADDIU: result = src_a + simm;
            OP_SLL:            result = src_b << shift_amount;
            OP_SRL:            result = src_b >> shift_amount;
            OP_SRA:            result = WORD_W'($signed(src_b) >>> shift_amount);
            OP_SLLV:           result = src_b << var_amt;
            OP_SRLV:           result = src_b >> var_amt;
            OP_SRAV:           result = WORD_W'($signed(src_b) >>> var_amt);
            OP_MFHI:           result = hi_val;
            OP_MFLO:           result = lo_val;
            default:           writes_register = 1'b0;
        endcase
    end

endmodule

`default_nettype wire

[src/malu_muldiv.sv]
// Iterative unsigned 32x32 multiply and 32/32 divide sharing one 33-bit adder.
// One bit per cycle; depends on malu_pkg for widths and control structs.
`default_nettype none

module malu_muldiv
    import malu_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  md_cmd_t           cmd,
    input  logic [WORD_W-1:0] op_a,
    input  logic [WORD_W-1:0] op_b,
    output md_stat_t          stat,
    output logic [WORD_W-1:0] hi_out,
    output logic [WORD_W-1:0] lo_out
);

    logic                  run_reg, run_next;
    logic                  div_reg, div_next;
    logic [STEP_CNT_W-1:0] cnt_reg, cnt_next;
    logic [WORD_W-1:0]     hi_reg, hi_next;
    logic [WORD_W-1:0]     lo_reg, lo_next;
    logic [WORD_W-1:0]     b_reg, b_next;

    logic [WORD_W:0]   add_x;
    logic [WORD_W:0]   add_y;
    logic              add_sub;
    logic [WORD_W+1:0] add_sum;
    logic              last_step;

    // Shared adder: the multiply adds the multiplicand to HI, the divide
    // subtracts the divisor from the shifted partial remainder.
    always_comb begin
        if (div_reg) begin
            add_x   = {hi_reg, lo_reg[WORD_W-1]};
            add_y   = ~{1'b0, b_reg};
            add_sub = 1'b1;
        end else begin
            add_x   = {1'b0, hi_reg};
            add_y   = {1'b0, b_reg};
            add_sub = 1'b0;
        end
    end

    assign add_sum = {1'b0, add_x} + {1'b0, add_y} + {{(WORD_W+1){1'b0}}, add_sub};
    assign last_step = run_reg && (cnt_reg == {STEP_CNT_W{1'b1}});

    // Step control and the HI/LO shift register.
    always_comb begin
        run_next = run_reg;
        div_next = div_reg;
        cnt_next = cnt_reg;
        hi_next  = hi_reg;
        lo_next  = lo_reg;
        b_next   = b_reg;
        if (cmd.start && !run_reg) begin
            run_next = 1'b1;
            div_next = cmd.is_div;
            cnt_next = '0;
            b_next   = op_b;
            hi_next  = '0;
            // Multiply holds the multiplier in LO, divide the dividend.
            lo_next  = cmd.is_div ? op_a : op_b;
            if (!cmd.is_div) begin
                b_next = op_a;
            end
        end else if (run_reg) begin
            cnt_next = cnt_reg + 1'b1;
            if (last_step) begin
                run_next = 1'b0;
            end
            if (div_reg) begin
                // A carry out means no borrow: the divisor fits.
                if (add_sum[WORD_W+1]) begin
                    hi_next = add_sum[WORD_W-1:0];
                end else begin
                    hi_next = add_x[WORD_W-1:0];
                end
                lo_next = {lo_reg[WORD_W-2:0], add_sum[WORD_W+1]};
            end else begin
                if (lo_reg[0]) begin
                    hi_next = add_sum[WORD_W:1];
                    lo_next = {add_sum[0], lo_reg[WORD_W-1:1]};
                end else begin
                    hi_next = {1'b0, hi_reg[WORD_W-1:1]};
                    lo_next = {hi_reg[0], lo_reg[WORD_W-1:1]};
                end
            end
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            run_reg <= run_next;
            cnt_reg <= cnt_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        div_reg <= div_next;
        hi_reg  <= hi_next;
        lo_reg  <= lo_next;
        b_reg   <= b_next;
    end

    assign stat.busy = run_reg;
    assign stat.done = last_step;
    assign hi_out    = hi_reg;
    assign lo_out    = lo_reg;

endmodule

`default_nettype wire

[src/mips_integer_alu_hilo.sv]
// Path: ALU operations go from the operand registers to the output register; mult
// and div go through the 32 one-bit steps of the shared multiply/divide adder
// before the output register. No new request is taken until the previous one is
// loaded into the output register, and that load waits until the register is free.
// A request is taken while an earlier result still waits in the output register.
// Reset (aresetn low, synchronous) clears HI, LO, the sequencer and the output valid flag.
`default_nettype none

module mips_integer_alu_hilo
    import malu_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [31:0] src_a, [63:32] src_b, [79:64] immediate, [84:80] shift_amount
    input  logic [S_TDATA_W-1:0] s_tdata,
    // [4:0] req_type
    input  logic [OP_W-1:0]      s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [31:0] result
    output logic [M_TDATA_W-1:0] m_tdata,
    // [0] writes_register
    output logic                 m_tuser
);

    state_t             state_reg, state_next;
    op_t                op_reg;
    logic [WORD_W-1:0]  a_reg;
    logic [WORD_W-1:0]  b_reg;
    logic [IMM_W-1:0]   imm_reg;
    logic [SHAMT_W-1:0] sh_reg;
    logic [WORD_W-1:0]  hi_reg, hi_next;
    logic [WORD_W-1:0]  lo_reg, lo_next;
    logic               out_valid_reg, out_valid_next;
    logic [WORD_W-1:0]  out_data_reg;
    logic               out_wr_reg;

    logic               load_req;
    logic               out_load;
    logic               hilo_from_md;
    logic               out_free;
    logic               is_muldiv;
    md_cmd_t            md_cmd;
    md_stat_t           md_stat;
    logic [WORD_W-1:0]  md_hi;
    logic [WORD_W-1:0]  md_lo;
    logic [WORD_W-1:0]  alu_result;
    logic               alu_wr;

    malu_alu u_alu (
        .op              (op_reg),
        .src_a           (a_reg),
        .src_b           (b_reg),
        .immediate       (imm_reg),
        .shift_amount    (sh_reg),
        .hi_val          (hi_reg),
        .lo_val          (lo_reg),
        .result          (alu_result),
        .writes_register (alu_wr)
    );

    malu_muldiv u_muldiv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (md_cmd),
        .op_a    (a_reg),
        .op_b    (b_reg),
        .stat    (md_stat),
        .hi_out  (md_hi),
        .lo_out  (md_lo)
    );

    assign out_free  = !out_valid_reg || m_tready;
    assign is_muldiv = op_reg inside {OP_DIV, OP_MULT};

    // Sequencer: next state and control outputs.
    always_comb begin
        state_next    = state_reg;
        s_tready      = 1'b0;
        load_req      = 1'b0;
        out_load      = 1'b0;
        hilo_from_md  = 1'b0;
        md_cmd.start  = 1'b0;
        md_cmd.is_div = (op_reg == OP_DIV);
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    load_req   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (is_muldiv) begin
                    md_cmd.start = 1'b1;
                    state_next   = ST_ITER;
                end else if (out_free) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_ITER: begin
                if (md_stat.done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    out_load     = 1'b1;
                    hilo_from_md = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // HI/LO update from the unit or from a move-to request.
    always_comb begin
        hi_next = hi_reg;
        lo_next = lo_reg;
        if (hilo_from_md) begin
            hi_next = md_hi;
            lo_next = md_lo;
        end else if (out_load && op_reg == OP_MTHI) begin
            hi_next = a_reg;
        end else if (out_load && op_reg == OP_MTLO) begin
            lo_next = a_reg;
        end
    end

    // Output valid: set when a result is loaded, cleared when it is taken.
    always_comb begin
        out_valid_next = out_valid_reg;
        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    // Control state and architectural HI/LO.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            hi_reg        <= '0;
            lo_reg        <= '0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            hi_reg        <= hi_next;
            lo_reg        <= lo_next;
        end
    end

    // Request operand and output payload registers.
    always_ff @(posedge aclk) begin
        if (load_req) begin
            op_reg  <= op_t'(s_tuser);
            a_reg   <= s_tdata[31:0];
            b_reg   <= s_tdata[63:32];
            imm_reg <= s_tdata[79:64];
            sh_reg  <= s_tdata[84:80];
        end
        if (out_load) begin
            out_data_reg <= alu_result;
            out_wr_reg   <= alu_wr;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_wr_reg;

endmodule

`default_nettype wire
